/* rtl/core/selective_repeat_sender_window_core_macros.svh */
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core_macros.svh
// Assertion helpers used by the sender window engine.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SRSW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRSW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg
// Widths, event and result codes, and shared types of the sender window.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W  = 31;
    localparam int TIME_W = 32;
    localparam int TO_W   = 16;
    localparam int LIM_W  = 7;
    localparam int ACT_W  = 3;
    localparam int KIND_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // highest sequence number; never admitted
    localparam logic [SEQ_W-1:0] SEQ_TOP = 31'h7FFF_FFFF;

    // event codes
    localparam logic [ACT_W-1:0] ACT_NEW      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_END      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACK      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INTERVAL = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SCAN     = 3'd4;

    // result codes
    localparam logic [KIND_W-1:0] KIND_ADMIT   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RETX    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOTHING = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd1;

    // reset values
    localparam logic [TO_W-1:0]  TIMEOUT_RST = 16'd10;
    localparam logic [LIM_W-1:0] LIMIT_RST   = 7'd64;

    // configuration handed from the register block to the engine
    typedef struct packed {
        logic [TO_W-1:0]  timeout;
        logic [LIM_W-1:0] limit;
    } cfg_t;

endpackage

/* rtl/core/srsw_ram.sv */
// ----------------------------------------------------------------------------
// srsw_ram
// Send time store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srsw_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/srsw_engine.sv */
// ----------------------------------------------------------------------------
// srsw_engine
// Window state, event sequencer and send time walk over the slot memory.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_core_macros.svh"

module srsw_engine #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SLOT_W       = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  srsw_pkg::cfg_t                     cfg,
    input  logic                               start,
    output logic                               busy,
    input  logic [srsw_pkg::ACT_W-1:0]         action,
    input  logic [srsw_pkg::SEQ_W-1:0]         seq_value,
    input  logic [srsw_pkg::SEQ_W-1:0]         interval_end,
    input  logic [srsw_pkg::TIME_W-1:0]        now_ms,
    output logic                               result_valid,
    output logic [srsw_pkg::KIND_W-1:0]        kind,
    output logic [srsw_pkg::SEQ_W-1:0]         seq_number,
    output logic                               last,
    output logic                               mem_wr_en,
    output logic [SLOT_W-1:0]                  mem_wr_addr,
    output logic [srsw_pkg::TIME_W-1:0]        mem_wr_data,
    output logic                               mem_rd_en,
    output logic [SLOT_W-1:0]                  mem_rd_addr,
    input  logic [srsw_pkg::TIME_W-1:0]        mem_rd_data
);

    localparam int SEQ_W  = srsw_pkg::SEQ_W;
    localparam int OCC_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = OCC_W + 1;
    localparam logic [SUM_W-1:0]           DEPTH_SUM = SUM_W'(WINDOW_DEPTH);
    localparam logic [srsw_pkg::LIM_W-1:0] DEPTH_LIM = srsw_pkg::LIM_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0]          SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // window state
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  nxt_reg, nxt_next;
    logic              ended_reg, ended_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [SLOT_W-1:0] base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0] nxt_slot_reg, nxt_slot_next;

    // latched event
    logic [srsw_pkg::ACT_W-1:0]  act_reg, act_next;
    logic [SEQ_W-1:0]            seqv_reg, seqv_next;
    logic [SEQ_W-1:0]            iend_reg, iend_next;
    logic [srsw_pkg::TIME_W-1:0] now_reg, now_next;

    // walk
    logic [SEQ_W-1:0]  cur_reg, cur_next;
    logic [SEQ_W-1:0]  hi_reg, hi_next;
    logic              empty_reg, empty_next;
    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic              rd_v_reg, rd_v_next;
    logic [SEQ_W-1:0]  rd_seq_reg, rd_seq_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;
    logic              pend_v_reg, pend_v_next;
    logic [SEQ_W-1:0]  pend_seq_reg, pend_seq_next;

    // result register
    logic                        res_v_reg, res_v_next;
    logic [srsw_pkg::KIND_W-1:0] res_kind_reg, res_kind_next;
    logic [SEQ_W-1:0]            res_seq_reg, res_seq_next;
    logic                        res_last_reg, res_last_next;

    // datapath
    logic [srsw_pkg::LIM_W-1:0]  lim;
    logic                        admit;
    logic                        ack_move;
    logic                        ack_sat;
    logic [SEQ_W-1:0]            ack_base;
    logic [SEQ_W-1:0]            ack_delta_wide;
    logic [OCC_W-1:0]            ack_delta;
    logic                        ack_done;
    logic                        is_scan;
    logic [SEQ_W-1:0]            nxt_m1;
    logic [SEQ_W-1:0]            rng_lo;
    logic [SEQ_W-1:0]            rng_hi;
    logic [SEQ_W-1:0]            setup_off_wide;
    logic [OCC_W-1:0]            add_in;
    logic [SUM_W-1:0]            slot_sum;
    logic [SLOT_W-1:0]           slot_wrap;
    logic [srsw_pkg::TIME_W-1:0] age;
    logic [srsw_pkg::TIME_W-1:0] tmo_wide;
    logic                        due;
    logic [SUM_W-1:0]            chk_sum;
    logic [SLOT_W-1:0]           chk_slot;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_v_reg;
    assign kind         = res_kind_reg;
    assign seq_number   = res_seq_reg;
    assign last         = res_last_reg;

    // admission check
    assign lim   = (cfg.limit < DEPTH_LIM) ? cfg.limit : DEPTH_LIM;
    assign admit = !ended_reg && (srsw_pkg::LIM_W'(occ_reg) < lim)
                   && (nxt_reg != srsw_pkg::SEQ_TOP);

    // cumulative ack; advance is at most the outstanding count
    assign ack_move       = (seqv_reg >= base_reg);
    assign ack_sat        = (seqv_reg >= nxt_reg);
    assign ack_base       = ack_sat ? nxt_reg : (seqv_reg + SEQ_W'(1));
    assign ack_delta_wide = seqv_reg + SEQ_W'(1) - base_reg;
    assign ack_delta      = ack_sat ? occ_reg : ack_delta_wide[OCC_W-1:0];
    assign ack_done       = ended_reg && (nxt_reg != '0) && (seqv_reg == nxt_m1);

    // resend range clipped to the window
    assign is_scan = (act_reg == srsw_pkg::ACT_SCAN);
    assign nxt_m1  = nxt_reg - SEQ_W'(1);
    assign rng_lo  = (is_scan || (seqv_reg < base_reg)) ? base_reg : seqv_reg;
    assign rng_hi  = (!is_scan && (iend_reg < nxt_m1)) ? iend_reg : nxt_m1;

    // slot of base plus an in-window offset (shared by ack and walk setup)
    assign setup_off_wide = cur_reg - base_reg;
    assign add_in    = (state_reg == ST_SETUP) ? setup_off_wide[OCC_W-1:0] : ack_delta;
    assign slot_sum  = SUM_W'(base_slot_reg) + SUM_W'(add_in);
    assign slot_wrap = (slot_sum >= DEPTH_SUM) ? SLOT_W'(slot_sum - DEPTH_SUM)
                                               : SLOT_W'(slot_sum);

    // age test on returned send time; interval is strict, scan is not
    assign age      = now_reg - mem_rd_data;
    assign tmo_wide = srsw_pkg::TIME_W'(cfg.timeout);
    assign due      = (act_reg == srsw_pkg::ACT_INTERVAL) ? (age > tmo_wide)
                                                          : (age >= tmo_wide);

    // memory ports
    always_comb
    begin
        mem_rd_en   = (state_reg == ST_WALK);
        mem_rd_addr = cur_slot_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = rd_slot_reg;
        mem_wr_data = now_reg;
        if (state_reg == ST_EXEC && act_reg == srsw_pkg::ACT_NEW && admit)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = nxt_slot_reg;
        end
        else if (rd_v_reg && due)
        begin
            mem_wr_en   = 1'b1;
        end
    end

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        nxt_next       = nxt_reg;
        ended_next     = ended_reg;
        occ_next       = occ_reg;
        base_slot_next = base_slot_reg;
        nxt_slot_next  = nxt_slot_reg;
        act_next       = act_reg;
        seqv_next      = seqv_reg;
        iend_next      = iend_reg;
        now_next       = now_reg;
        cur_next       = cur_reg;
        hi_next        = hi_reg;
        empty_next     = empty_reg;
        cur_slot_next  = cur_slot_reg;
        rd_v_next      = 1'b0;
        rd_seq_next    = cur_reg;
        rd_slot_next   = cur_slot_reg;
        pend_v_next    = pend_v_reg;
        pend_seq_next  = pend_seq_reg;
        res_v_next     = 1'b0;
        res_kind_next  = res_kind_reg;
        res_seq_next   = res_seq_reg;
        res_last_next  = res_last_reg;

        // a due slot from the read stage: flush the held result, hold this one
        if (rd_v_reg && due)
        begin
            if (pend_v_reg)
            begin
                res_v_next    = 1'b1;
                res_kind_next = srsw_pkg::KIND_RETX;
                res_seq_next  = pend_seq_reg;
                res_last_next = 1'b0;
            end
            pend_v_next   = 1'b1;
            pend_seq_next = rd_seq_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    seqv_next  = seq_value;
                    iend_next  = interval_end;
                    now_next   = now_ms;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                case (act_reg)
                    srsw_pkg::ACT_NEW:
                    begin
                        res_v_next    = 1'b1;
                        res_last_next = 1'b1;
                        if (admit)
                        begin
                            res_kind_next = srsw_pkg::KIND_ADMIT;
                            res_seq_next  = nxt_reg;
                            nxt_next      = nxt_reg + SEQ_W'(1);
                            occ_next      = occ_reg + OCC_W'(1);
                            nxt_slot_next = (nxt_slot_reg == SLOT_LAST) ? '0
                                            : nxt_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            res_kind_next = srsw_pkg::KIND_FULL;
                            res_seq_next  = base_reg;
                        end
                    end
                    srsw_pkg::ACT_END:
                    begin
                        ended_next = 1'b1;
                    end
                    srsw_pkg::ACT_ACK:
                    begin
                        res_v_next    = 1'b1;
                        res_last_next = 1'b1;
                        res_kind_next = ack_done ? srsw_pkg::KIND_DONE : srsw_pkg::KIND_ACK;
                        res_seq_next  = base_reg;
                        if (ack_move)
                        begin
                            base_next      = ack_base;
                            occ_next       = occ_reg - ack_delta;
                            base_slot_next = slot_wrap;
                            res_seq_next   = ack_base;
                        end
                    end
                    srsw_pkg::ACT_INTERVAL,
                    srsw_pkg::ACT_SCAN:
                    begin
                        cur_next   = rng_lo;
                        hi_next    = rng_hi;
                        empty_next = (nxt_reg == '0) || (rng_lo > rng_hi);
                        state_next = ST_SETUP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SETUP:
            begin
                if (empty_reg)
                begin
                    res_v_next    = 1'b1;
                    res_kind_next = srsw_pkg::KIND_NOTHING;
                    res_seq_next  = base_reg;
                    res_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cur_slot_next = slot_wrap;
                    pend_v_next   = 1'b0;
                    state_next    = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // one slot read per cycle
                rd_v_next = 1'b1;
                if (cur_reg == hi_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cur_next      = cur_reg + SEQ_W'(1);
                    cur_slot_next = (cur_slot_reg == SLOT_LAST) ? '0
                                    : cur_slot_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                res_v_next    = 1'b1;
                res_last_next = 1'b1;
                if (pend_v_reg)
                begin
                    res_kind_next = srsw_pkg::KIND_RETX;
                    res_seq_next  = pend_seq_reg;
                end
                else
                begin
                    res_kind_next = srsw_pkg::KIND_NOTHING;
                    res_seq_next  = base_reg;
                end
                pend_v_next = 1'b0;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            nxt_reg       <= '0;
            ended_reg     <= 1'b0;
            occ_reg       <= '0;
            base_slot_reg <= '0;
            nxt_slot_reg  <= '0;
            rd_v_reg      <= 1'b0;
            pend_v_reg    <= 1'b0;
            res_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            nxt_reg       <= nxt_next;
            ended_reg     <= ended_next;
            occ_reg       <= occ_next;
            base_slot_reg <= base_slot_next;
            nxt_slot_reg  <= nxt_slot_next;
            rd_v_reg      <= rd_v_next;
            pend_v_reg    <= pend_v_next;
            res_v_reg     <= res_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        seqv_reg     <= seqv_next;
        iend_reg     <= iend_next;
        now_reg      <= now_next;
        cur_reg      <= cur_next;
        hi_reg       <= hi_next;
        empty_reg    <= empty_next;
        cur_slot_reg <= cur_slot_next;
        rd_seq_reg   <= rd_seq_next;
        rd_slot_reg  <= rd_slot_next;
        pend_seq_reg <= pend_seq_next;
        res_kind_reg <= res_kind_next;
        res_seq_reg  <= res_seq_next;
        res_last_reg <= res_last_next;
    end

    // slot of next sequence must follow from base slot and outstanding count
    assign chk_sum  = SUM_W'(base_slot_reg) + SUM_W'(occ_reg);
    assign chk_slot = (chk_sum >= DEPTH_SUM) ? SLOT_W'(chk_sum - DEPTH_SUM)
                                             : SLOT_W'(chk_sum);

    `SRSW_ASSERT_NOW(a_slot_track, clk, rst_n, 1'b1, nxt_slot_reg == chk_slot, "next slot out of step with base slot")
    `SRSW_ASSERT_NOW(a_base_order, clk, rst_n, 1'b1, (base_reg <= nxt_reg) && (SEQ_W'(occ_reg) == nxt_reg - base_reg), "window base and count inconsistent")
    `SRSW_ASSERT_NOW(a_rmw_apart, clk, rst_n, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write hit the same slot")
    `SRSW_ASSERT_NEXT(a_finish_last, clk, rst_n, state_reg == ST_FINISH, res_v_reg && res_last_reg, "walk ended without final result")

endmodule

/* rtl/core/selective_repeat_sender_window_core.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_window_core
// Sender window of a selective-repeat transfer with per-slot send times.
//
// Events are accepted when start is high and busy is low; the block then stays
// busy until the event is done. Results come out at most one per cycle on the
// result ports, each marked by result_valid for exactly one cycle, and cannot
// be held off: the receiver must take every beat. New packet and ack events
// give one result beat each; end of data and unknown codes give none. An
// interval or timeout scan walks the window slots in the clipped range (at most
// WINDOW_DEPTH of them), or gives a single nothing beat when that range is empty;
// the send time memory is read one slot per cycle through its
// single read port while due slots are rewritten behind the read. The final
// result of each event that has one carries last. Configuration writes are taken at any
// time with cfg_ready high, but are meant to be issued only while the block is
// idle.
// ----------------------------------------------------------------------------
module selective_repeat_sender_window_core #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // event channel
    input  logic                                start,
    output logic                                busy,
    input  logic [srsw_pkg::ACT_W-1:0]          action,
    input  logic [srsw_pkg::SEQ_W-1:0]          seq_value,
    input  logic [srsw_pkg::SEQ_W-1:0]          interval_end,
    input  logic [srsw_pkg::TIME_W-1:0]         now_ms,
    // result channel
    output logic                                result_valid,
    output logic [srsw_pkg::KIND_W-1:0]         kind,
    output logic [srsw_pkg::SEQ_W-1:0]          seq_number,
    output logic                                last,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    srsw_pkg::cfg_t cfg_reg, cfg_next;

    logic                        mem_wr_en;
    logic [SLOT_W-1:0]           mem_wr_addr;
    logic [srsw_pkg::TIME_W-1:0] mem_wr_data;
    logic                        mem_rd_en;
    logic [SLOT_W-1:0]           mem_rd_addr;
    logic [srsw_pkg::TIME_W-1:0] mem_rd_data;

    assign cfg_ready = 1'b1;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                srsw_pkg::CFG_TIMEOUT: cfg_next.timeout = cfg_data;
                srsw_pkg::CFG_LIMIT:   cfg_next.limit   = cfg_data[srsw_pkg::LIM_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout <= srsw_pkg::TIMEOUT_RST;
            cfg_reg.limit   <= srsw_pkg::LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // event sequencer and window state
    srsw_engine #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_W       (SLOT_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .seq_value    (seq_value),
        .interval_end (interval_end),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .kind         (kind),
        .seq_number   (seq_number),
        .last         (last),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data)
    );

    // send time per window slot
    srsw_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .ADDR_W (SLOT_W),
        .DATA_W (srsw_pkg::TIME_W)
    ) u_send_time (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

/* bench/srsw_checker.sv */
// ----------------------------------------------------------------------------
// srsw_checker
// Watches the event, result and register channels of the sender window,
// keeps its own copy of the window state and the register values, works out
// the result beats each accepted event must produce, and compares every
// result beat field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module srsw_checker
    import srsw_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [ACT_W-1:0]      action,
    input  logic [SEQ_W-1:0]      seq_value,
    input  logic [SEQ_W-1:0]      interval_end,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  result_valid,
    input  logic [KIND_W-1:0]     kind,
    input  logic [SEQ_W-1:0]      seq_number,
    input  logic                  last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic              last;
    } report_t;

    // shadow of the register block and the window state
    logic [TO_W-1:0]   timeout_q;
    logic [LIM_W-1:0]  limit_q;
    logic [SEQ_W-1:0]  win_base;
    logic [SEQ_W-1:0]  next_seq;
    logic              end_seen;
    logic [TIME_W-1:0] stamp [WINDOW_DEPTH];

    // result beats owed by the block, oldest first
    report_t owed_reports [$];

    function automatic void owe(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] s, logic l);
        report_t r;
        r.kind = k;
        r.seq  = s;
        r.last = l;
        owed_reports.push_back(r);
    endfunction

    // Walk the in-window part of [lo_in, hi_in] in ascending order and resend
    // every packet old enough; returns how many were resent.
    function automatic int resend_due(logic [SEQ_W-1:0] lo_in, logic [SEQ_W-1:0] hi_in,
                                      logic [TIME_W-1:0] now, bit at_least);
        logic [SEQ_W:0]    lo;
        logic [SEQ_W:0]    hi;
        logic [SEQ_W:0]    s;
        logic [TIME_W-1:0] age;
        int                slot;
        int                count;
        count = 0;
        if (next_seq == '0)
            return 0;
        lo = (lo_in < win_base) ? win_base : lo_in;
        hi = (hi_in > next_seq - 1'b1) ? next_seq - 1'b1 : hi_in;
        for (s = lo; s <= hi; s++)
        begin
            slot = int'(s % WINDOW_DEPTH);
            age  = now - stamp[slot];
            if (at_least ? (age >= timeout_q) : (age > timeout_q))
            begin
                stamp[slot] = now;
                owe(KIND_RETX, s[SEQ_W-1:0], 1'b0);
                count++;
            end
        end
        return count;
    endfunction

    // State update and owed results for one accepted event
    function automatic void apply_event(logic [ACT_W-1:0] a, logic [SEQ_W-1:0] sv,
                                        logic [SEQ_W-1:0] ie, logic [TIME_W-1:0] now);
        logic [LIM_W-1:0] lim_eff;
        logic             done;
        int               n;
        lim_eff = (limit_q < WINDOW_DEPTH) ? limit_q : LIM_W'(WINDOW_DEPTH);
        n = 0;
        case (a)
            ACT_NEW:
            begin
                if (!end_seen && (next_seq - win_base) < lim_eff && next_seq < SEQ_TOP)
                begin
                    stamp[int'(next_seq % WINDOW_DEPTH)] = now;
                    owe(KIND_ADMIT, next_seq, 1'b1);
                    next_seq = next_seq + 1'b1;
                end
                else
                    owe(KIND_FULL, win_base, 1'b1);
            end
            ACT_END:
                end_seen = 1'b1;
            ACT_ACK:
            begin
                if (sv >= win_base)
                    win_base = (sv >= next_seq) ? next_seq : sv + 1'b1;
                done = end_seen && next_seq != '0 && sv == next_seq - 1'b1;
                owe(done ? KIND_DONE : KIND_ACK, win_base, 1'b1);
            end
            ACT_INTERVAL, ACT_SCAN:
            begin
                if (a == ACT_INTERVAL)
                    n = resend_due(sv, ie, now, 1'b0);
                else
                    n = resend_due(win_base, SEQ_TOP, now, 1'b1);
                if (n == 0)
                    owe(KIND_NOTHING, win_base, 1'b1);
                else
                    owed_reports[owed_reports.size()-1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Compare result beats, follow register writes, predict accepted events
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            timeout_q = TIMEOUT_RST;
            limit_q   = LIMIT_RST;
            win_base  = '0;
            next_seq  = '0;
            end_seen  = 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                stamp[i] = '0;
            owed_reports.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (owed_reports.size() == 0)
                begin
                    $error("result beat with nothing owed: kind %0d seq_number %0d last %0b",
                           kind, seq_number, last);
                    errs++;
                end
                else
                begin
                    want = owed_reports.pop_front();
                    if (kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, kind);
                        errs++;
                    end
                    if (seq_number !== want.seq)
                    begin
                        $error("seq_number: expected %0d, got %0d", want.seq, seq_number);
                        errs++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        errs++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_TIMEOUT)
                    timeout_q = cfg_data;
                else if (cfg_index == CFG_LIMIT)
                    limit_q = cfg_data[LIM_W-1:0];
            end

            if (start && !busy)
                apply_event(action, seq_value, interval_end, now_ms);

            mismatches  <= mismatches + errs;
            outstanding <= owed_reports.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the selective-repeat sender window. A directed
// opening covers empty-window scans, wrap of the millisecond clock, strict
// versus at-least age tests, reversed and out-of-window intervals and acks
// below and beyond the window. Random phases follow under several register
// settings, then end of data, completion acks and one more random phase.
// Checking is done by srsw_checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import srsw_pkg::*;

    localparam int DEPTH       = 64;
    localparam int SETTLE      = 2 * DEPTH + 16;
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ACT_W-1:0]      action;
    logic [SEQ_W-1:0]      seq_value;
    logic [SEQ_W-1:0]      interval_end;
    logic [TIME_W-1:0]     now_ms;
    logic                  result_valid;
    logic [KIND_W-1:0]     kind;
    logic [SEQ_W-1:0]      seq_number;
    logic                  last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatches;
    int                    outstanding;
    int                    cycle_count;
    int                    no_idle_left;
    logic [TO_W-1:0]       timeout_now;
    logic [TIME_W-1:0]     clock_ms;
    // window edges as last seen on the result channel, used to aim stimulus
    logic [SEQ_W-1:0]      base_hint;
    logic [SEQ_W-1:0]      next_hint;

    selective_repeat_sender_window_core #(
        .WINDOW_DEPTH(DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .seq_value    (seq_value),
        .interval_end (interval_end),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .kind         (kind),
        .seq_number   (seq_number),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    srsw_checker #(
        .WINDOW_DEPTH(DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .seq_value    (seq_value),
        .interval_end (interval_end),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .kind         (kind),
        .seq_number   (seq_number),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // follow the window edges from result beats
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (kind == KIND_ADMIT)
                next_hint <= seq_number + 1'b1;
            else if (kind != KIND_RETX)
                base_hint <= seq_number;
        end
    end

    // One event beat: hold start until the block takes it
    task automatic issue(input logic [ACT_W-1:0] a, input logic [SEQ_W-1:0] sv,
                         input logic [SEQ_W-1:0] ie, input logic [TIME_W-1:0] t);
        start        <= 1'b1;
        action       <= a;
        seq_value    <= sv;
        interval_end <= ie;
        now_ms       <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Random gap after a beat; mostly short, a few long, some bursts with none
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (no_idle_left > 0)
            no_idle_left--;
        else if (r < 4)
            no_idle_left = $urandom_range(10, 30);
        else if (r < 50)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 20);
        else
            n = $urandom_range(21, 90);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Wait for the block to go quiet with nothing owed
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [TO_W-1:0] to, input logic [CFG_DATA_W-1:0] lim);
        drain();
        write_reg(CFG_TIMEOUT, to);
        write_reg(CFG_LIMIT, lim);
        cfg_valid   <= 1'b0;
        timeout_now = to;
    endtask

    // Advance the millisecond clock; mostly small steps, some past the timeout
    function automatic logic [TIME_W-1:0] next_now();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            clock_ms = $urandom();
        else if (r < 5)
            clock_ms = clock_ms + $urandom();
        else if (r < 22)
            clock_ms = clock_ms + timeout_now + $urandom_range(0, 2);
        else
            clock_ms = clock_ms + $urandom_range(0, timeout_now / 4 + 3);
        return clock_ms;
    endfunction

    // Random events aimed mostly at the live window
    task automatic random_events(input int count);
        int               r;
        int               span;
        logic [ACT_W-1:0] a;
        logic [SEQ_W-1:0] sv;
        logic [SEQ_W-1:0] ie;
        logic [SEQ_W-1:0] floor_seq;
        repeat (count)
        begin
            r    = $urandom_range(0, 99);
            span = (next_hint >= base_hint) ? int'(next_hint - base_hint) : 0;
            sv   = SEQ_W'($urandom());
            ie   = SEQ_W'($urandom());
            floor_seq = (base_hint > 2) ? base_hint - 2'd2 : '0;
            if (r < 36)
                a = ACT_NEW;
            else if (r < 60)
            begin
                a = ACT_ACK;
                r = $urandom_range(0, 99);
                if (r < 72)
                    sv = base_hint + SEQ_W'($urandom_range(0, span));
                else if (r < 90)
                    sv = SEQ_W'($urandom_range(0, base_hint));
            end
            else if (r < 78)
            begin
                a = ACT_INTERVAL;
                r = $urandom_range(0, 99);
                if (r < 90)
                begin
                    sv = floor_seq + SEQ_W'($urandom_range(0, span + 3));
                    if (r < 76)
                        ie = sv + SEQ_W'($urandom_range(0, 24));
                    else
                        ie = sv - SEQ_W'($urandom_range(1, 5));
                end
            end
            else if (r < 93)
                a = ACT_SCAN;
            else
                a = ACT_W'($urandom_range(5, 7));
            issue(a, sv, ie, next_now());
            idle_gap();
        end
    endtask

    // Main sequence
    initial
    begin
        logic [TIME_W-1:0] t0;
        start        = 1'b0;
        action       = ACT_NEW;
        seq_value    = '0;
        interval_end = '0;
        now_ms       = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TIMEOUT;
        cfg_data     = '0;
        cycle_count  = 0;
        no_idle_left = 0;
        base_hint    = '0;
        next_hint    = '0;
        timeout_now  = TIMEOUT_RST;
        t0           = 32'hFFFF_FFF0;
        rst_n        = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, reset register values, window near clock wrap
        issue(ACT_SCAN, '0, '0, t0);                       // empty window
        idle_gap();
        issue(ACT_INTERVAL, '0, SEQ_TOP, t0);              // empty window
        idle_gap();
        issue(ACT_ACK, '0, '0, t0);                        // ack with nothing sent
        idle_gap();
        repeat (4)
        begin
            issue(ACT_NEW, '0, '0, t0);
            idle_gap();
        end
        issue(ACT_INTERVAL, 31'd3, 31'd1, t0 + 32'd20);    // reversed interval
        idle_gap();
        issue(ACT_INTERVAL, '0, SEQ_TOP, t0 + 32'd10);     // age equals timeout: kept
        idle_gap();
        issue(ACT_SCAN, '0, '0, t0 + 32'd10);              // age equals timeout: resent
        idle_gap();
        issue(ACT_INTERVAL, 31'd1, 31'd2, t0 + 32'd21);    // ages across clock wrap
        idle_gap();
        issue(ACT_ACK, 31'd1, '0, t0 + 32'd21);
        idle_gap();
        issue(ACT_ACK, '0, '0, t0 + 32'd21);               // below base
        idle_gap();
        issue(ACT_INTERVAL, '0, 31'd1, t0 + 32'd40);       // entirely below base
        idle_gap();
        issue(ACT_NEW, '0, '0, t0 + 32'd40);
        idle_gap();
        issue(ACT_ACK, SEQ_TOP, SEQ_TOP, 32'hFFFF_FFFF);    // beyond next: saturates
        idle_gap();
        issue(ACT_SCAN, SEQ_TOP, SEQ_TOP, 32'hFFFF_FFFF);   // empty again
        idle_gap();
        issue(ACT_W'(5), SEQ_TOP, SEQ_TOP, 32'hFFFF_FFFF);  // unknown codes
        idle_gap();
        issue(ACT_W'(6), '0, '0, '0);
        idle_gap();
        issue(ACT_W'(7), SEQ_TOP, '0, 32'hFFFF_FFFF);
        idle_gap();
        issue(ACT_NEW, SEQ_TOP, SEQ_TOP, t0 + 32'd41);
        clock_ms = t0 + 32'd41;

        // random phases under different register settings
        program_regs('0, 16'd1);                           // zero timeout, one slot
        random_events(70);
        program_regs(16'hFFFF, 16'd64);                    // longest timeout, full window
        random_events(70);
        program_regs(TO_W'($urandom_range(1, 40)), 16'd0); // no admission at all
        random_events(30);
        program_regs(16'd20, 16'hFFFF);                    // limit above depth
        random_events(80);
        program_regs(TO_W'($urandom_range(1, 200)), CFG_DATA_W'($urandom_range(1, 64)));
        random_events(90);
        program_regs(16'd5, 16'd8);
        random_events(80);

        // end of data, then completion acks
        drain();
        issue(ACT_END, '0, '0, clock_ms);
        idle_gap();
        issue(ACT_NEW, '0, '0, next_now());
        idle_gap();
        drain();
        issue(ACT_ACK, next_hint - 1'b1, '0, next_now());
        idle_gap();
        issue(ACT_ACK, next_hint - 1'b1, '0, next_now());
        idle_gap();
        issue(ACT_SCAN, '0, '0, next_now());
        idle_gap();
        random_events(40);

        drain();
        if (outstanding != 0)
            $error("%0d result beats never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
